/* rtl/tlvg_pkg.sv */
// Shared types, constants and register codes for the vector grouping block.
`default_nettype none

package tlvg_pkg;

  localparam int ELEM_W         = 32;
  localparam int SCEN_W         = 16;
  localparam int THR_W          = 24;
  localparam int EPS_W          = 16;
  localparam int GIDX_W         = 4;
  localparam int DIFF_SHIFT     = 16;
  localparam int PROD_W         = THR_W + ELEM_W;
  localparam int LHS_W          = ELEM_W + DIFF_SHIFT;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 24;
  localparam int VECTOR_LEN_DEF = 16;
  localparam int MAX_GROUPS_DEF = 16;

  localparam logic [THR_W-1:0] THR_RESET = 24'd6554;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  localparam logic [CFG_IDX_W-1:0] REG_REL_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS_OFFSET    = 1'd1;

  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN,
    ST_EVAL,
    ST_COPY,
    ST_COPY_END,
    ST_DONE_MATCH,
    ST_DONE_NEW,
    ST_DONE_FULL
  } state_t;

  typedef struct packed {
    logic              op;
    logic              kind;
    logic [SCEN_W-1:0] scenario_index;
    logic [ELEM_W-1:0] element_value;
    logic              last_element;
  } item_t;

  typedef struct packed {
    logic [GIDX_W-1:0] group_index;
    logic              new_group;
    logic              store_full;
    logic              kind_out;
    logic [SCEN_W-1:0] scenario_out;
  } res_t;

  typedef struct packed {
    logic take;
    logic idx_clear;
    logic issue;
    logic next_rep;
    logic copy_issue;
    logic finish;
    logic fin_new;
    logic fin_full;
  } cmd_t;

  typedef struct packed {
    logic starts_scan;
    logic grp_lt_cnt;
    logic grp_lt_max;
    logic idx_last;
    logic pipe_busy;
    logic match;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/tlvg_if.sv */
// Stream interfaces for the input element channel and the result channel.
`default_nettype none

interface tlvg_item_if import tlvg_pkg::*;;
  logic              valid;
  logic              ready;
  logic              op;
  logic              kind;
  logic [SCEN_W-1:0] scenario_index;
  logic [ELEM_W-1:0] element_value;
  logic              last_element;

  modport source (output valid, op, kind, scenario_index, element_value, last_element,
                  input ready);
  modport sink (input valid, op, kind, scenario_index, element_value, last_element,
                output ready);
endinterface

interface tlvg_result_if import tlvg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [GIDX_W-1:0] group_index;
  logic              new_group;
  logic              store_full;
  logic              kind_out;
  logic [SCEN_W-1:0] scenario_out;

  modport source (output valid, group_index, new_group, store_full, kind_out, scenario_out,
                  input ready);
  modport sink (input valid, group_index, new_group, store_full, kind_out, scenario_out,
                output ready);
endinterface

`default_nettype wire

/* rtl/tlvg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tlvg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/tlvg_ctrl.sv */
// Sequencer for loading, representative scan, copy and result hand-off.
`default_nettype none

module tlvg_ctrl import tlvg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid && st.starts_scan) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (st.grp_lt_cnt) state_next = ST_ISSUE;
        else if (st.grp_lt_max) state_next = ST_COPY;
        else state_next = ST_DONE_FULL;
      end
      ST_ISSUE: begin
        if (st.idx_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!st.pipe_busy) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = st.match ? ST_DONE_MATCH : ST_CHECK;
      end
      ST_COPY: begin
        if (st.idx_last) state_next = ST_COPY_END;
      end
      ST_COPY_END: state_next = ST_DONE_NEW;
      ST_DONE_MATCH, ST_DONE_NEW, ST_DONE_FULL: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.take   = item_valid;
      end
      ST_CHECK:    cmd.idx_clear  = 1'b1;
      ST_ISSUE:    cmd.issue      = 1'b1;
      ST_DRAIN:    ;
      ST_EVAL:     cmd.next_rep   = !st.match;
      ST_COPY:     cmd.copy_issue = 1'b1;
      ST_COPY_END: ;
      ST_DONE_MATCH: cmd.finish = st.out_free;
      ST_DONE_NEW: begin
        cmd.finish  = st.out_free;
        cmd.fin_new = 1'b1;
      end
      ST_DONE_FULL: begin
        cmd.finish   = st.out_free;
        cmd.fin_full = 1'b1;
      end
      default: ;
    endcase
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !st.pipe_busy)
    else $error("compare pipeline busy while idle");

  a_issue_fills_pipe: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> st.pipe_busy)
    else $error("issued read did not enter compare pipeline");

endmodule

`default_nettype wire

/* rtl/tlvg_datapath.sv */
// Element buffer, representative store, tolerance compare pipeline and result register.
`default_nettype none

module tlvg_datapath import tlvg_pkg::*; #(
  parameter int VECTOR_LEN = VECTOR_LEN_DEF,
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire item_t                 item,
  input  wire cmd_t                  cmd,
  output status_t                    st,
  input  wire logic                  res_ready,
  output logic                       res_valid,
  output res_t                       res
);

  localparam int IW        = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int EW        = $clog2(VECTOR_LEN + 1);
  localparam int GW        = $clog2(MAX_GROUPS + 1);
  localparam int REP_DEPTH = 2 * MAX_GROUPS * VECTOR_LEN;
  localparam int AW        = $clog2(REP_DEPTH);
  localparam int KIND_SPAN = MAX_GROUPS * VECTOR_LEN;

  logic [THR_W-1:0]  thr;
  logic [EPS_W-1:0]  eps;
  logic [EW-1:0]     ecnt;
  logic [GW-1:0]     gcnt [2];
  logic              kind_r;
  logic [SCEN_W-1:0] scen_r;
  logic [GW-1:0]     grp;
  logic [IW-1:0]     idx;
  logic [AW-1:0]     rep_base;

  logic              p1_v, p1_mask, p2_v, p3_v, c_v, match_acc;
  logic [AW-1:0]     c_addr;
  logic [ELEM_W-1:0] diff2, den2;
  logic [LHS_W-1:0]  lhs3;
  logic [PROD_W-1:0] prod3;

  logic [ELEM_W-1:0] buf_q, rep_q, val;
  logic [ELEM_W:0]   sub;
  logic [ELEM_W+1:0] sum;
  logic [ELEM_W-1:0] diff, den;
  logic [PROD_W-1:0] prod;
  logic              close;
  logic              buf_we;

  assign buf_we = cmd.take && item.op == OP_ELEMENT && ecnt < EW'(VECTOR_LEN);

  tlvg_ram #(.WIDTH(ELEM_W), .DEPTH(VECTOR_LEN)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (ecnt[IW-1:0]),
    .wdata (item.element_value),
    .raddr (idx),
    .rdata (buf_q)
  );

  tlvg_ram #(.WIDTH(ELEM_W), .DEPTH(REP_DEPTH)) u_rep (
    .clk   (clk),
    .we    (c_v),
    .waddr (c_addr),
    .wdata (val),
    .raddr (rep_base + AW'(idx)),
    .rdata (rep_q)
  );

  assign val   = p1_mask ? buf_q : '0;
  assign sub   = {rep_q[ELEM_W-1], rep_q} - {val[ELEM_W-1], val};
  assign diff  = sub[ELEM_W] ? ELEM_W'(-sub) : sub[ELEM_W-1:0];
  assign sum   = {{2{rep_q[ELEM_W-1]}}, rep_q} + (ELEM_W + 2)'(eps);
  assign den   = sum[ELEM_W+1] ? ELEM_W'(-sum) : sum[ELEM_W-1:0];
  assign prod  = thr * den2;
  assign close = PROD_W'(lhs3) <= prod3;

  assign st.starts_scan = item.op == OP_ELEMENT && item.last_element;
  assign st.grp_lt_cnt  = grp < gcnt[kind_r];
  assign st.grp_lt_max  = grp < GW'(MAX_GROUPS);
  assign st.idx_last    = idx == IW'(VECTOR_LEN - 1);
  assign st.pipe_busy   = p1_v || p2_v || p3_v;
  assign st.match       = match_acc;
  assign st.out_free    = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
      eps <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REL_THRESHOLD: thr <= cfg_data[THR_W-1:0];
        REG_EPS_OFFSET:    eps <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ecnt      <= '0;
      gcnt[0]   <= '0;
      gcnt[1]   <= '0;
      grp       <= '0;
      idx       <= '0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
      c_v       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p1_v <= cmd.issue;
      p2_v <= p1_v;
      p3_v <= p2_v;
      c_v  <= cmd.copy_issue;

      if (cmd.take) begin
        if (item.op == OP_CLEAR) begin
          ecnt    <= '0;
          gcnt[0] <= '0;
          gcnt[1] <= '0;
        end else begin
          if (ecnt < EW'(VECTOR_LEN)) ecnt <= ecnt + 1'b1;
          if (item.last_element) grp <= '0;
        end
      end

      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.issue || cmd.copy_issue) begin
        idx <= idx + 1'b1;
      end

      if (cmd.next_rep) grp <= grp + 1'b1;

      if (cmd.finish) begin
        ecnt      <= '0;
        res_valid <= 1'b1;
        if (cmd.fin_new) gcnt[kind_r] <= gcnt[kind_r] + 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_mask <= EW'(idx) < ecnt;
    diff2   <= diff;
    den2    <= den;
    lhs3    <= {diff2, DIFF_SHIFT'(0)};
    prod3   <= prod;
    c_addr  <= rep_base + AW'(idx);

    if (cmd.take && st.starts_scan) begin
      kind_r   <= item.kind;
      scen_r   <= item.scenario_index;
      rep_base <= item.kind ? AW'(KIND_SPAN) : '0;
    end else if (cmd.next_rep) begin
      rep_base <= rep_base + AW'(VECTOR_LEN);
    end

    if (cmd.idx_clear) begin
      match_acc <= 1'b1;
    end else if (p3_v && !close) begin
      match_acc <= 1'b0;
    end

    if (cmd.finish) begin
      res.group_index  <= cmd.fin_full ? '0 : GIDX_W'(grp);
      res.new_group    <= cmd.fin_new;
      res.store_full   <= cmd.fin_full;
      res.kind_out     <= kind_r;
      res.scenario_out <= scen_r;
    end
  end

  a_copy_no_scan: assert property (@(posedge clk) disable iff (rst)
    c_v |-> !p1_v)
    else $error("representative copy overlaps compare");

  a_new_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && cmd.fin_new |-> gcnt[kind_r] < GW'(MAX_GROUPS))
    else $error("new group opened in a full store");

endmodule

`default_nettype wire

/* rtl/threshold_leader_vector_grouping_top.sv */
// Top level of the leader clustering block with relative tolerance.
//
// Channels: items carries one vector element per transaction (op, kind,
// scenario_index, element_value, last_element); op set clears both stores.
// results carries one transaction per finished vector: group_index,
// new_group, store_full, kind_out and scenario_out.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 rel_threshold, 1 eps_offset) at a rising edge; write only when idle.
// Throughput: elements that are not last are taken one per cycle while the
// sequencer is idle. After the last element the sequencer walks the n
// stored representatives of the kind; for each it issues one buffer and
// store read per cycle, then drains the compare and multiply pipeline
// (p1, p2, p3). A match ends the walk; otherwise the element buffer is
// copied into the free slot if the store of that kind has room, and the
// result reports store_full if not.
// Reset: synchronous; empties both stores and the element buffer and loads
// the register defaults. No clearing pass is needed.
// Stall: the result register holds while results.ready is low; element
// loading goes on meanwhile, and a finished scan waits for the register.
`default_nettype none

module threshold_leader_vector_grouping_top import tlvg_pkg::*; #(
  parameter int VECTOR_LEN = VECTOR_LEN_DEF,
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  tlvg_item_if.sink                  items,
  tlvg_result_if.source              results
);

  item_t   item;
  res_t    res;
  cmd_t    cmd;
  status_t st;
  logic    item_ready;
  logic    res_valid;

  assign item.op             = items.op;
  assign item.kind           = items.kind;
  assign item.scenario_index = items.scenario_index;
  assign item.element_value  = items.element_value;
  assign item.last_element   = items.last_element;
  assign items.ready         = item_ready;

  assign results.valid       = res_valid;
  assign results.group_index = res.group_index;
  assign results.new_group   = res.new_group;
  assign results.store_full  = res.store_full;
  assign results.kind_out    = res.kind_out;
  assign results.scenario_out = res.scenario_out;

  tlvg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  tlvg_datapath #(
    .VECTOR_LEN (VECTOR_LEN),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .st        (st),
    .res_ready (results.ready),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

`default_nettype wire
